// ----- hdl/cqsc_pkg.sv -----
// shared constants for the player command queue with seek coalescing
`default_nettype none

package cqsc_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMD_W = 2;
   localparam int TIME_W = 48;
   localparam int ENTRY_W = CMD_W + TIME_W;
   localparam int PEND_W = 5;

   localparam logic [CMD_W-1:0] OP_PLAY = 2'd0;
   localparam logic [CMD_W-1:0] OP_PAUSE = 2'd1;
   localparam logic [CMD_W-1:0] OP_SEEK = 2'd2;
   localparam logic [CMD_W-1:0] OP_POP = 2'd3;

endpackage

`default_nettype wire

// ----- hdl/command_queue_seek_coalescing.sv -----
// top level: player command queue held in a ring buffer ram, with seek coalescing
//
// Each request beat yields exactly one response beat. Commands live in a
// single-port-write, registered-read ring buffer of cqsc_pkg::QUEUE_DEPTH entries.
// A play or pause push writes the ram straight from idle, a pop makes one ram
// read, and a pop on an empty queue reads nothing.
// A seek push walks the queue once through the ram, one entry per cycle,
// dropping pending seeks and closing the gaps, then appends the new seek.
// A new request is taken while the previous response beat still waits in
// the output register; work finishes only once that register is free.
`default_nettype none

module command_queue_seek_coalescing (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [cqsc_pkg::CMD_W-1:0]    req_cmd,
   input  wire  [cqsc_pkg::TIME_W-1:0]   req_seek_time,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic                          rsp_popped_valid,
   output logic [cqsc_pkg::CMD_W-1:0]    rsp_popped_command,
   output logic [cqsc_pkg::TIME_W-1:0]   rsp_popped_time,
   output logic                          rsp_push_dropped,
   output logic [cqsc_pkg::PEND_W-1:0]   rsp_pending_count
);

   localparam int ADDR_W = cqsc_pkg::ADDR_W;
   localparam int CNT_W = cqsc_pkg::CNT_W;
   localparam int CMD_W = cqsc_pkg::CMD_W;
   localparam int TIME_W = cqsc_pkg::TIME_W;
   localparam int ENTRY_W = cqsc_pkg::ENTRY_W;
   localparam int PEND_W = cqsc_pkg::PEND_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_APPEND,
      ST_FINISH
   } state_type;

   state_type state_ff;

   logic [ENTRY_W-1:0] mem [cqsc_pkg::QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [ADDR_W-1:0]  head_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   rd_idx_ff;
   logic [CNT_W-1:0]   wr_idx_ff;
   logic [TIME_W-1:0]  time_ff;

   logic               res_valid_ff;
   logic [CMD_W-1:0]   res_cmd_ff;
   logic [TIME_W-1:0]  res_time_ff;
   logic               res_dropped_ff;

   logic               rsp_valid_ff;
   logic               rsp_popped_valid_ff;
   logic [CMD_W-1:0]   rsp_popped_command_ff;
   logic [TIME_W-1:0]  rsp_popped_time_ff;
   logic               rsp_push_dropped_ff;
   logic [PEND_W-1:0]  rsp_pending_count_ff;

   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;

   logic [CNT_W+PEND_W-1:0] count_wide;
   logic                    rd_is_seek;
   logic                    out_free;

   function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
      if (sum >= (CNT_W+1)'(cqsc_pkg::QUEUE_DEPTH)) begin
         sum = sum - (CNT_W+1)'(cqsc_pkg::QUEUE_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign rd_is_seek = (rd_data_ff[ENTRY_W-1:TIME_W] == cqsc_pkg::OP_SEEK);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign count_wide = {{PEND_W{1'b0}}, count_ff};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_popped_valid = rsp_popped_valid_ff;
   assign rsp_popped_command = rsp_popped_command_ff;
   assign rsp_popped_time = rsp_popped_time_ff;
   assign rsp_push_dropped = rsp_push_dropped_ff;
   assign rsp_pending_count = rsp_pending_count_ff;

   // ram access control
   always_comb begin
      mem_rd_en = 1'b0;
      mem_rd_addr = head_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = head_ff;
      mem_wr_data = rd_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == cqsc_pkg::OP_POP || req_cmd == cqsc_pkg::OP_SEEK) begin
                  mem_rd_en = (count_ff != '0);
               end else if (count_ff != CNT_W'(cqsc_pkg::QUEUE_DEPTH)) begin
                  mem_wr_en = 1'b1;
                  mem_wr_addr = ring_addr(head_ff, count_ff);
                  mem_wr_data = {req_cmd, {TIME_W{1'b0}}};
               end
            end
         end
         ST_SCAN: begin
            if (!rd_is_seek) begin
               mem_wr_en = 1'b1;
               mem_wr_addr = ring_addr(head_ff, wr_idx_ff);
            end
            if (rd_idx_ff != count_ff) begin
               mem_rd_en = 1'b1;
               mem_rd_addr = ring_addr(head_ff, rd_idx_ff);
            end
         end
         ST_APPEND: begin
            if (wr_idx_ff != CNT_W'(cqsc_pkg::QUEUE_DEPTH)) begin
               mem_wr_en = 1'b1;
               mem_wr_addr = ring_addr(head_ff, wr_idx_ff);
               mem_wr_data = {cqsc_pkg::OP_SEEK, time_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // entry ram, registered read
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  time_ff <= req_seek_time;
                  res_valid_ff <= 1'b0;
                  res_cmd_ff <= '0;
                  res_time_ff <= '0;
                  res_dropped_ff <= 1'b0;
                  wr_idx_ff <= '0;
                  rd_idx_ff <= CNT_W'(1);
                  case (req_cmd)
                     cqsc_pkg::OP_POP: begin
                        state_ff <= (count_ff != '0) ? ST_POP : ST_FINISH;
                     end
                     cqsc_pkg::OP_SEEK: begin
                        state_ff <= (count_ff != '0) ? ST_SCAN : ST_APPEND;
                     end
                     default: begin
                        if (count_ff == CNT_W'(cqsc_pkg::QUEUE_DEPTH)) begin
                           res_dropped_ff <= 1'b1;
                        end else begin
                           count_ff <= count_ff + CNT_W'(1);
                        end
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_POP: begin
               res_valid_ff <= 1'b1;
               res_cmd_ff <= rd_data_ff[ENTRY_W-1:TIME_W];
               res_time_ff <= rd_data_ff[TIME_W-1:0];
               head_ff <= ring_addr(head_ff, CNT_W'(1));
               count_ff <= count_ff - CNT_W'(1);
               state_ff <= ST_FINISH;
            end
            ST_SCAN: begin
               if (!rd_is_seek) begin
                  wr_idx_ff <= wr_idx_ff + CNT_W'(1);
               end
               if (rd_idx_ff == count_ff) begin
                  state_ff <= ST_APPEND;
               end else begin
                  rd_idx_ff <= rd_idx_ff + CNT_W'(1);
               end
            end
            ST_APPEND: begin
               if (wr_idx_ff == CNT_W'(cqsc_pkg::QUEUE_DEPTH)) begin
                  res_dropped_ff <= 1'b1;
               end else begin
                  count_ff <= wr_idx_ff + CNT_W'(1);
               end
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_popped_valid_ff <= res_valid_ff;
                  rsp_popped_command_ff <= res_cmd_ff;
                  rsp_popped_time_ff <= res_time_ff;
                  rsp_push_dropped_ff <= res_dropped_ff;
                  rsp_pending_count_ff <= count_wide[PEND_W-1:0];
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(cqsc_pkg::QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_compact_behind_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> wr_idx_ff < rd_idx_ff)
      else $error("compaction write index passed read index");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> count_ff != '0)
      else $error("pop read issued on empty queue");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ST_IDLE)
      else $error("accepted beat not processed");

   a_no_ram_access_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> !mem_wr_en && !mem_rd_en)
      else $error("ram access while holding result");

endmodule

`default_nettype wire
